FILE: hdl/cpi_pkg.sv
package cpi_pkg;

    // Filter geometry: two phases of TAPS_PER_PHASE taps each.
    localparam int TAPS_PER_PHASE = 15;
    localparam int COEF_COUNT     = 2 * TAPS_PER_PHASE;

    // The adder tree sums the products in groups, then sums the groups.
    localparam int GROUP_SIZE = 4;
    localparam int NUM_GROUPS = (TAPS_PER_PHASE + GROUP_SIZE - 1) / GROUP_SIZE;

    // Command codes of an input transaction.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Phase codes: the odd phase goes out first, the even phase closes the pair.
    localparam logic PHASE_ODD  = 1'b0;
    localparam logic PHASE_EVEN = 1'b1;

    typedef logic [31:0] t_acc;

    typedef struct packed {
        logic               command;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic [4:0]         coef_index;
        logic signed [15:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_re;
        logic signed [15:0] out_im;
        logic               last_of_pair;
    } t_out_item;

    // Registered products of one phase.
    typedef struct packed {
        logic                           last;
        t_acc [TAPS_PER_PHASE-1:0]      prod_re;
        t_acc [TAPS_PER_PHASE-1:0]      prod_im;
    } t_prod_bus;

endpackage

FILE: hdl/cpi_front.sv
module cpi_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cpi_pkg::t_in_item  i_in_item,
    output logic               o_prod_valid,
    input  logic               i_prod_ready,
    output cpi_pkg::t_prod_bus o_prod
);

    logic                    r_s0_valid;
    cpi_pkg::t_in_item       r_s0_item;
    logic                    r_phase;
    logic                    r_prod_valid;
    cpi_pkg::t_prod_bus      r_prod;
    logic signed [15:0]      r_coef    [cpi_pkg::COEF_COUNT];
    logic signed [15:0]      r_hist_re [cpi_pkg::TAPS_PER_PHASE];
    logic signed [15:0]      r_hist_im [cpi_pkg::TAPS_PER_PHASE];

    logic                    prod_en;
    logic                    s0_fire;
    logic                    s0_is_load;
    logic                    s0_done;
    logic                    in_accept;
    cpi_pkg::t_prod_bus      n_prod;

    // Issue control: a sample stays in the issue register until both of its phases have issued.
    assign prod_en    = !r_prod_valid || i_prod_ready;
    assign s0_fire    = r_s0_valid && prod_en;
    assign s0_is_load = (r_s0_item.command == cpi_pkg::CMD_LOAD);
    assign s0_done    = s0_fire && (s0_is_load || (r_phase == cpi_pkg::PHASE_EVEN));
    assign o_in_ready = !r_s0_valid || s0_done;
    assign in_accept  = i_in_valid && o_in_ready;

    // Issue register and phase counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_phase    <= cpi_pkg::PHASE_ODD;
        end else begin
            if (in_accept) begin
                r_s0_valid <= 1'b1;
                r_phase    <= cpi_pkg::PHASE_ODD;
            end else if (s0_done) begin
                r_s0_valid <= 1'b0;
            end else if (s0_fire && !s0_is_load) begin
                r_phase <= cpi_pkg::PHASE_EVEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s0_item <= i_in_item;
        end
    end

    // Coefficient store; loads beyond the store are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < cpi_pkg::COEF_COUNT; j++) begin
                r_coef[j] <= '0;
            end
        end else if (s0_fire && s0_is_load) begin
            for (int j = 0; j < cpi_pkg::COEF_COUNT; j++) begin
                if (int'(r_s0_item.coef_index) == j) begin
                    r_coef[j] <= r_s0_item.coef_value;
                end
            end
        end
    end

    // Sample history shifts once both phases have read it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cpi_pkg::TAPS_PER_PHASE; k++) begin
                r_hist_re[k] <= '0;
                r_hist_im[k] <= '0;
            end
        end else if (s0_fire && !s0_is_load && (r_phase == cpi_pkg::PHASE_EVEN)) begin
            for (int k = 0; k < cpi_pkg::TAPS_PER_PHASE - 1; k++) begin
                r_hist_re[k] <= r_hist_re[k+1];
                r_hist_im[k] <= r_hist_im[k+1];
            end
            r_hist_re[cpi_pkg::TAPS_PER_PHASE-1] <= r_s0_item.sample_re;
            r_hist_im[cpi_pkg::TAPS_PER_PHASE-1] <= r_s0_item.sample_im;
        end
    end

    // One multiplier per tap and lane, coefficient chosen by phase.
    always_comb begin
        logic signed [15:0] coef;
        logic signed [31:0] mul_re;
        logic signed [31:0] mul_im;
        n_prod      = r_prod;
        n_prod.last = (r_phase == cpi_pkg::PHASE_EVEN);
        for (int k = 0; k < cpi_pkg::TAPS_PER_PHASE; k++) begin
            coef   = (r_phase == cpi_pkg::PHASE_EVEN) ? r_coef[2*k] : r_coef[2*k+1];
            mul_re = coef * r_hist_re[k];
            mul_im = coef * r_hist_im[k];
            n_prod.prod_re[k] = cpi_pkg::t_acc'(mul_re);
            n_prod.prod_im[k] = cpi_pkg::t_acc'(mul_im);
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (prod_en) begin
            r_prod_valid <= s0_fire && !s0_is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_fire && !s0_is_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod_valid = r_prod_valid;
    assign o_prod       = r_prod;

endmodule

FILE: hdl/cpi_adder.sv
module cpi_adder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_prod_valid,
    output logic               o_prod_ready,
    input  cpi_pkg::t_prod_bus i_prod,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cpi_pkg::t_out_item o_out_item
);

    logic                                 r_part_valid;
    logic                                 r_part_last;
    cpi_pkg::t_acc [cpi_pkg::NUM_GROUPS-1:0] r_part_re;
    cpi_pkg::t_acc [cpi_pkg::NUM_GROUPS-1:0] r_part_im;
    cpi_pkg::t_acc [cpi_pkg::NUM_GROUPS-1:0] n_part_re;
    cpi_pkg::t_acc [cpi_pkg::NUM_GROUPS-1:0] n_part_im;
    logic                                 r_out_valid;
    cpi_pkg::t_out_item                   r_out_item;
    cpi_pkg::t_out_item                   n_out_item;
    logic                                 out_en;

    assign out_en       = !r_out_valid || i_out_ready;
    assign o_prod_ready = !r_part_valid || out_en;

    // First tree level: wrapping sums over groups of products.
    always_comb begin
        for (int g = 0; g < cpi_pkg::NUM_GROUPS; g++) begin
            n_part_re[g] = '0;
            n_part_im[g] = '0;
        end
        for (int k = 0; k < cpi_pkg::TAPS_PER_PHASE; k++) begin
            n_part_re[k / cpi_pkg::GROUP_SIZE] = n_part_re[k / cpi_pkg::GROUP_SIZE]
                                                 + i_prod.prod_re[k];
            n_part_im[k / cpi_pkg::GROUP_SIZE] = n_part_im[k / cpi_pkg::GROUP_SIZE]
                                                 + i_prod.prod_im[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_valid <= 1'b0;
        end else if (o_prod_ready) begin
            r_part_valid <= i_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_prod_ready && i_prod_valid) begin
            r_part_re   <= n_part_re;
            r_part_im   <= n_part_im;
            r_part_last <= i_prod.last;
        end
    end

    // Second tree level: sum the groups and keep the upper half.
    always_comb begin
        cpi_pkg::t_acc sum_re;
        cpi_pkg::t_acc sum_im;
        sum_re = '0;
        sum_im = '0;
        for (int g = 0; g < cpi_pkg::NUM_GROUPS; g++) begin
            sum_re = sum_re + r_part_re[g];
            sum_im = sum_im + r_part_im[g];
        end
        n_out_item.out_re       = sum_re[31:16];
        n_out_item.out_im       = sum_im[31:16];
        n_out_item.last_of_pair = r_part_last;
    end

    // Output register, holds a result until the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_part_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_part_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: hdl/complex_polyphase_interpolator_x2.sv
// Each sample yields two results, odd phase first, each passing the issue, product,
// partial-sum and output registers; a coefficient load is stored on issue.
// Throughput: a new sample waits for the shared per-tap multipliers, which serve the odd
// phase and then the even phase; one load per cycle while the product stage can accept.
// Reset (synchronous, active low) empties the pipeline and zeroes history and coefficients.
module complex_polyphase_interpolator_x2 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cpi_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cpi_pkg::t_out_item o_out_item
);

    logic               prod_valid;
    logic               prod_ready;
    cpi_pkg::t_prod_bus prod;

    // Issue, coefficient store, history and multipliers.
    cpi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_prod_valid (prod_valid),
        .i_prod_ready (prod_ready),
        .o_prod       (prod)
    );

    // Registered adder tree and output register.
    cpi_adder u_adder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prod_valid (prod_valid),
        .o_prod_ready (prod_ready),
        .i_prod       (prod),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule
